FILE: design/windowed_stats_classifier_core_assert.svh
// assertion macros used by the checker file
`ifndef WINDOWED_STATS_CLASSIFIER_CORE_ASSERT_SVH
`define WINDOWED_STATS_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, muted during reset
`define WSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, muted during reset
`define WSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define WSC_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

FILE: design/wsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg
// Types, widths and class thresholds shared by the classifier files.
// ----------------------------------------------------------------------------
package wsc_pkg;

  localparam int ENTROPY_W = 9;
  localparam int MISS_W    = 32;
  localparam int CLASS_W   = 3;
  localparam int MEAN_W    = 29;

  // entropy saturation point, 1.0 in Q8
  localparam logic [ENTROPY_W-1:0] ENTROPY_ONE = 9'd256;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // class thresholds
  localparam logic [ENTROPY_W-1:0] E_SOURCE     = 9'd230;
  localparam logic [ENTROPY_W-1:0] E_SPIRAL     = 9'd179;
  localparam logic [ENTROPY_W-1:0] E_LEMNISCATE = 9'd128;
  localparam logic [ENTROPY_W-1:0] E_STRANGE    = 9'd77;
  localparam logic [ENTROPY_W-1:0] E_LIMIT      = 9'd26;
  localparam logic [MISS_W-1:0]    M_SOURCE     = 32'd800;
  localparam logic [MISS_W-1:0]    M_SPIRAL     = 32'd500;
  localparam logic [MISS_W-1:0]    V_LEMNISCATE = 32'd5000;
  localparam logic [MISS_W-1:0]    V_LIMIT      = 32'd1000;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SOURCE,
    CLS_SPIRAL,
    CLS_LEMNISCATE,
    CLS_STRANGE,
    CLS_LIMIT,
    CLS_TOROID
  } wsc_class_t;

  typedef struct packed {
    logic [ENTROPY_W-1:0] entropy;
    logic [MISS_W-1:0]    miss;
  } wsc_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EDIV,
    ST_MDIV,
    ST_EFIX,
    ST_MFIX,
    ST_SQUARE,
    ST_SQLAST,
    ST_VDIV,
    ST_VQUOT,
    ST_VFIX,
    ST_DONE
  } wsc_state_t;

  // fixed-priority classification, first match wins
  function automatic wsc_class_t pick_class(input logic [ENTROPY_W-1:0] e_mean,
                                            input logic [MISS_W-1:0]    m_mean,
                                            input logic [MISS_W-1:0]    m_var);
    wsc_class_t cls;
    if (e_mean > E_SOURCE && m_mean > M_SOURCE) begin
      cls = CLS_SOURCE;
    end else if (e_mean > E_SPIRAL && m_mean > M_SPIRAL) begin
      cls = CLS_SPIRAL;
    end else if (e_mean > E_LEMNISCATE && m_var < V_LEMNISCATE) begin
      cls = CLS_LEMNISCATE;
    end else if (e_mean > E_STRANGE) begin
      cls = CLS_STRANGE;
    end else if (e_mean > E_LIMIT && m_var < V_LIMIT) begin
      cls = CLS_LIMIT;
    end else begin
      cls = CLS_TOROID;
    end
    return cls;
  endfunction

endpackage

FILE: design/wsc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_in_if
// Sample channel: entropy and miss score with valid/ready.
// ----------------------------------------------------------------------------
interface wsc_in_if import wsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ENTROPY_W-1:0] entropy_q8;
  logic [MISS_W-1:0]    miss_sample;

  modport source (output valid, output entropy_q8, output miss_sample, input ready);
  modport sink   (input valid, input entropy_q8, input miss_sample, output ready);
endinterface

FILE: design/wsc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_out_if
// Result channel: class and window statistics with valid/ready.
// ----------------------------------------------------------------------------
interface wsc_out_if import wsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CLASS_W-1:0]   class_code;
  logic [ENTROPY_W-1:0] entropy_mean;
  logic [MEAN_W-1:0]    miss_mean;
  logic [MEAN_W-1:0]    miss_variance;

  modport source (output valid, output class_code, output entropy_mean,
                  output miss_mean, output miss_variance, input ready);
  modport sink   (input valid, input class_code, input entropy_mean,
                  input miss_mean, input miss_variance, output ready);
endinterface

FILE: design/windowed_stats_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_stats_classifier_core
// Sliding-window entropy and miss-score statistics with six-way classifier.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one result transfer, in order. The
// statistics engine steps its single shared 32x32 multiplier, which forms the
// entropy and miss means by reciprocal multiply and then squares the window
// deviations one entry per cycle. A two-entry queue lets samples arrive while
// the engine is busy, and the result register lets the engine finish the next
// item while a result waits. The window starts out all zero after reset.
module windowed_stats_classifier_core import wsc_pkg::*; #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  wsc_in_if.sink    samples,
  wsc_out_if.source results
);

  logic      push_valid;
  logic      push_ready;
  wsc_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  wsc_item_t pop_item;

  // input stage
  wsc_front u_front (
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  wsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // statistics engine
  wsc_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .results   (results)
  );

endmodule

FILE: design/wsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_front
// Input stage: takes sample transfers, saturates entropy at 1.0 and pushes
// the item into the queue.
// ----------------------------------------------------------------------------
module wsc_front import wsc_pkg::*; (
  wsc_in_if.sink     samples,
  output logic       push_valid,
  input  logic       push_ready,
  output wsc_item_t  push_item
);

  // handshake passes straight to the queue
  assign push_valid    = samples.valid;
  assign samples.ready = push_ready;

  // entropy above one saturates
  always_comb begin
    push_item.miss    = samples.miss_sample;
    push_item.entropy = (samples.entropy_q8 > ENTROPY_ONE) ? ENTROPY_ONE
                                                           : samples.entropy_q8;
  end

endmodule

FILE: design/wsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_queue
// Small FIFO between the front and the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module wsc_queue import wsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  wsc_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output wsc_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  wsc_item_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/wsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_back
// Statistics engine: keeps the sample window, running sums, and steps one
// shared 32x32 multiplier through means, squared deviations and variance.
// ----------------------------------------------------------------------------
module wsc_back import wsc_pkg::*; #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  wsc_item_t  pop_item,
  wsc_out_if.source  results
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int ESUM_W = $clog2(WINDOW_DEPTH * 256 + 1);
  localparam logic [MISS_W-1:0] RECIP   = 32'((64'd1 << 32) / WINDOW_DEPTH);
  localparam logic [MISS_W-1:0] DEPTH_C = 32'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

  // window storage, unwritten entries read as zero
  logic [ENTROPY_W-1:0]    e_mem [WINDOW_DEPTH];
  logic [MISS_W-1:0]       m_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] filled;
  logic [ENTROPY_W-1:0]    rd_e;
  logic [MISS_W-1:0]       rd_m;
  logic                    rd_ok;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;

  wsc_state_t state;
  wsc_state_t state_next;

  logic [IDX_W-1:0]     slot;
  logic [IDX_W-1:0]     k;
  wsc_item_t            cur;
  logic [ESUM_W-1:0]    e_sum;
  logic [MISS_W-1:0]    m_sum;
  logic [MISS_W-1:0]    var_sum;
  logic [MISS_W-1:0]    e_qest;
  logic [MISS_W-1:0]    m_qest;
  logic [MISS_W-1:0]    v_qest;
  logic [ENTROPY_W-1:0] e_mean;
  logic [MISS_W-1:0]    m_mean;
  logic [MISS_W-1:0]    m_var;
  logic [2*MISS_W-1:0]  prod;
  logic [MISS_W-1:0]    mul_a;
  logic [MISS_W-1:0]    mul_b;

  logic [ENTROPY_W-1:0] old_e;
  logic [MISS_W-1:0]    old_m;
  logic [MISS_W-1:0]    abs_dev;
  logic                 load_out;

  logic                 out_valid;
  wsc_class_t           out_class;
  logic [ENTROPY_W-1:0] out_e_mean;
  logic [MEAN_W-1:0]    out_m_mean;
  logic [MEAN_W-1:0]    out_m_var;

  // quotient estimate from the reciprocal is low by at most one
  function automatic logic [MISS_W-1:0] fix_quot(input logic [MISS_W-1:0] x,
                                                 input logic [MISS_W-1:0] q);
    logic [MISS_W-1:0] r;
    r = x - q * DEPTH_C;
    return (r >= DEPTH_C) ? q + 1'b1 : q;
  endfunction

  assign old_e   = rd_ok ? rd_e : '0;
  assign old_m   = rd_ok ? rd_m : '0;
  assign abs_dev = (old_m > m_mean) ? old_m - m_mean : m_mean - old_m;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (pop_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_EDIV;
      ST_EDIV:   state_next = ST_MDIV;
      ST_MDIV:   state_next = ST_EFIX;
      ST_EFIX:   state_next = ST_MFIX;
      ST_MFIX:   state_next = ST_SQUARE;
      ST_SQUARE: if (k == LAST_IDX) state_next = ST_SQLAST;
      ST_SQLAST: state_next = ST_VDIV;
      ST_VDIV:   state_next = ST_VQUOT;
      ST_VQUOT:  state_next = ST_VFIX;
      ST_VFIX:   state_next = ST_DONE;
      ST_DONE:   if (!out_valid || results.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs: queue pop, window port, multiplier operands, result load
  always_comb begin
    pop_ready = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = slot;
    mul_a     = '0;
    mul_b     = '0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:   pop_ready = 1'b1;
      ST_UPDATE: wr_en = 1'b1;
      ST_EDIV: begin
        mul_a = MISS_W'(e_sum);
        mul_b = RECIP;
      end
      ST_MDIV: begin
        mul_a = m_sum;
        mul_b = RECIP;
      end
      ST_MFIX:   rd_addr = '0;
      ST_SQUARE: begin
        rd_addr = k + 1'b1;
        mul_a   = abs_dev;
        mul_b   = abs_dev;
      end
      ST_VDIV: begin
        mul_a = var_sum;
        mul_b = RECIP;
      end
      ST_DONE:   load_out = !out_valid || results.ready;
      default:   ;
    endcase
  end

  // window memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      e_mem[slot] <= cur.entropy;
      m_mem[slot] <= cur.miss;
    end
    rd_e <= e_mem[rd_addr];
    rd_m <= m_mem[rd_addr];
  end

  // shared multiplier, one product per cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      slot   <= '0;
      k      <= '0;
      filled <= '0;
      rd_ok  <= 1'b0;
      e_sum  <= '0;
      m_sum  <= '0;
    end else begin
      state <= state_next;
      rd_ok <= filled[rd_addr];
      case (state)
        ST_UPDATE: begin
          e_sum        <= ESUM_W'(e_sum + ESUM_W'(cur.entropy) - ESUM_W'(old_e));
          m_sum        <= m_sum + cur.miss - old_m;
          filled[slot] <= 1'b1;
          slot         <= (slot == LAST_IDX) ? '0 : slot + 1'b1;
        end
        ST_MFIX:   k <= '0;
        ST_SQUARE: k <= k + 1'b1;
        default:   ;
      endcase
    end
  end

  // statistics datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:   if (pop_valid) cur <= pop_item;
      ST_MDIV:   e_qest <= prod[2*MISS_W-1:MISS_W];
      ST_EFIX: begin
        m_qest <= prod[2*MISS_W-1:MISS_W];
        e_mean <= ENTROPY_W'(fix_quot(MISS_W'(e_sum), e_qest));
      end
      ST_MFIX: begin
        m_mean  <= fix_quot(m_sum, m_qest);
        var_sum <= '0;
      end
      ST_SQUARE: if (k != '0) var_sum <= var_sum + prod[MISS_W-1:0];
      ST_SQLAST: var_sum <= var_sum + prod[MISS_W-1:0];
      ST_VQUOT:  v_qest <= prod[2*MISS_W-1:MISS_W];
      ST_VFIX:   m_var <= fix_quot(var_sum, v_qest);
      default:   ;
    endcase
  end

  // result register, holds until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_class  <= pick_class(e_mean, m_mean, m_var);
      out_e_mean <= e_mean;
      out_m_mean <= m_mean[MEAN_W-1:0];
      out_m_var  <= m_var[MEAN_W-1:0];
    end
  end

  assign results.valid         = out_valid;
  assign results.class_code    = out_class;
  assign results.entropy_mean  = out_e_mean;
  assign results.miss_mean     = out_m_mean;
  assign results.miss_variance = out_m_var;

endmodule

FILE: design/wsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_checker
// Port-level checks on the result channel of the classifier core.
// ----------------------------------------------------------------------------
`include "windowed_stats_classifier_core_assert.svh"

module wsc_checker import wsc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CLASS_W-1:0]   class_code,
  input logic [ENTROPY_W-1:0] entropy_mean,
  input logic [MEAN_W-1:0]    miss_mean,
  input logic [MEAN_W-1:0]    miss_variance
);

  // no result right after reset
  `WSC_ASSERT_RST(a_reset_quiet, clk, rst, !out_valid)

  // stalled result stays valid with class, miss mean and variance stable
  `WSC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(class_code) && $stable(miss_mean) && $stable(miss_variance))

  // entropy mean never exceeds one
  `WSC_ASSERT_IMP(a_emean_range, clk, rst, out_valid, entropy_mean <= ENTROPY_ONE)

  // low entropy always lands in the last class
  `WSC_ASSERT_IMP(a_low_toroid, clk, rst, out_valid && entropy_mean <= E_LIMIT, class_code == CLS_TOROID)

  // high entropy and high miss mean take the first class
  `WSC_ASSERT_IMP(a_high_source, clk, rst, out_valid && entropy_mean > E_SOURCE && miss_mean > M_SOURCE[MEAN_W-1:0], class_code == CLS_SOURCE)

endmodule

bind windowed_stats_classifier_core wsc_checker u_wsc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .class_code    (results.class_code),
  .entropy_mean  (results.entropy_mean),
  .miss_mean     (results.miss_mean),
  .miss_variance (results.miss_variance)
);

FILE: bench/tb_windowed_stats_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_stats_classifier_core
// Self-checking bench for the sliding-window classifier. A queue of samples
// (directed corners, then bursts of steady windows near the class thresholds
// mixed with raw noise) feeds a clocked driver. A window predictor computes
// the class and statistics of every accepted sample, and a clocked monitor
// compares each result transfer against the oldest prediction. The run
// goes through phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_windowed_stats_classifier_core;
  import wsc_pkg::*;

  localparam int WIN_DEPTH   = 8;
  localparam int NUM_SAMPLES = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [ENTROPY_W-1:0] entropy;
    logic [MISS_W-1:0]    miss;
    int                   tx_idle;
    int                   rx_stall;
    bit                   drain;
  } pending_sample_t;

  typedef struct {
    wsc_class_t           cls;
    logic [ENTROPY_W-1:0] e_mean;
    logic [MEAN_W-1:0]    m_mean;
    logic [MEAN_W-1:0]    m_var;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // bench-side copies of the block inputs, known from time zero
  logic                 s_valid   = 1'b0;
  logic [ENTROPY_W-1:0] s_entropy = '0;
  logic [MISS_W-1:0]    s_miss    = '0;
  logic                 r_ready   = 1'b0;

  wsc_in_if  samples_if ();
  wsc_out_if results_if ();

  assign samples_if.valid       = s_valid;
  assign samples_if.entropy_q8  = s_entropy;
  assign samples_if.miss_sample = s_miss;
  assign results_if.ready       = r_ready;

  windowed_stats_classifier_core #(.WINDOW_DEPTH(WIN_DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  pending_sample_t pending[$];
  window_result_t  window_results[$];

  int sent_cnt     = 0;
  int acc_cnt      = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int rx_stall_pct = 0;

  // predictor state
  logic [ENTROPY_W-1:0] e_ring [WIN_DEPTH];
  logic [MISS_W-1:0]    m_ring [WIN_DEPTH];
  logic [2:0]           fill_slot;

  // fixed-priority class pick over the window statistics
  function automatic wsc_class_t classify_window(input logic [ENTROPY_W-1:0] e_avg,
                                                 input logic [MISS_W-1:0]    m_avg,
                                                 input logic [MISS_W-1:0]    m_spread);
    if (e_avg > E_SOURCE && m_avg > M_SOURCE) return CLS_SOURCE;
    if (e_avg > E_SPIRAL && m_avg > M_SPIRAL) return CLS_SPIRAL;
    if (e_avg > E_LEMNISCATE && m_spread < V_LEMNISCATE) return CLS_LEMNISCATE;
    if (e_avg > E_STRANGE) return CLS_STRANGE;
    if (e_avg > E_LIMIT && m_spread < V_LIMIT) return CLS_LIMIT;
    return CLS_TOROID;
  endfunction

  // store one sample in the window and queue the statistics it produces
  task automatic update_window(input logic [ENTROPY_W-1:0] e_in,
                               input logic [MISS_W-1:0]    m_in);
    logic [ENTROPY_W-1:0] e_sat;
    logic [11:0]          e_sum;
    logic [MISS_W-1:0]    m_sum;
    logic [MISS_W-1:0]    m_avg;
    logic [MISS_W-1:0]    dev;
    logic [MISS_W-1:0]    sq;
    logic [MISS_W-1:0]    sq_sum;
    logic [MISS_W-1:0]    m_spread;
    window_result_t       res;
    e_sat = (e_in > ENTROPY_ONE) ? ENTROPY_ONE : e_in;
    e_ring[fill_slot] = e_sat;
    m_ring[fill_slot] = m_in;
    fill_slot = fill_slot + 3'd1;
    e_sum = '0;
    m_sum = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      e_sum = e_sum + e_ring[k];
      m_sum = m_sum + m_ring[k];
    end
    m_avg = m_sum >> 3;
    // squares and their sum wrap at 32 bits
    sq_sum = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      dev = (m_ring[k] > m_avg) ? (m_ring[k] - m_avg) : (m_avg - m_ring[k]);
      sq = dev * dev;
      sq_sum = sq_sum + sq;
    end
    m_spread = sq_sum >> 3;
    res.e_mean = e_sum[11:3];
    res.m_mean = m_avg[MEAN_W-1:0];
    res.m_var  = m_spread[MEAN_W-1:0];
    res.cls    = classify_window(e_sum[11:3], m_avg, m_spread);
    window_results.push_back(res);
  endtask

  task automatic push_sample(input logic [ENTROPY_W-1:0] e, input logic [MISS_W-1:0] m,
                             input int tx, input int rx, input bit drain);
    pending_sample_t p;
    p.entropy  = e;
    p.miss     = m;
    p.tx_idle  = tx;
    p.rx_stall = rx;
    p.drain    = drain;
    pending.push_back(p);
  endtask

  // driver: new values at the falling edge, held until the transfer
  always @(negedge clk) begin : drive
    pending_sample_t nxt;
    if (rst) begin
      s_valid <= 1'b0;
      r_ready <= 1'b0;
    end else begin
      r_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      if (sent_cnt == acc_cnt) begin
        if (pending.size() == 0) begin
          s_valid <= 1'b0;
        end else if (pending[0].drain && window_results.size() != 0) begin
          s_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < pending[0].tx_idle) begin
          s_valid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          s_valid      <= 1'b1;
          s_entropy    <= nxt.entropy;
          s_miss       <= nxt.miss;
          rx_stall_pct <= nxt.rx_stall;
          sent_cnt     <= sent_cnt + 1;
        end
      end
    end
  end

  // monitor: predict on sample transfers, check result transfers
  always @(posedge clk) begin : watch
    window_result_t exp_res;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, window_results.size());
      $display("windowed_stats_classifier_core: mismatch");
      $finish;
    end
    if (rst) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        e_ring[k] = '0;
        m_ring[k] = '0;
      end
      fill_slot = '0;
    end else begin
      // result check first: latency rules out same-edge pairs
      if (results_if.valid && results_if.ready) begin
        if (window_results.size() == 0) begin
          $display("%0t: unexpected result class %0d e_mean %0d m_mean %0d m_var %0d",
                   $time, results_if.class_code, results_if.entropy_mean,
                   results_if.miss_mean, results_if.miss_variance);
          err_cnt <= err_cnt + 1;
        end else begin
          exp_res = window_results.pop_front();
          if (results_if.class_code !== exp_res.cls ||
              results_if.entropy_mean !== exp_res.e_mean ||
              results_if.miss_mean !== exp_res.m_mean ||
              results_if.miss_variance !== exp_res.m_var) begin
            $display("%0t: expected class %0d e_mean %0d m_mean %0d m_var %0d", $time,
                     exp_res.cls, exp_res.e_mean, exp_res.m_mean, exp_res.m_var);
            $display("%0t: actual   class %0d e_mean %0d m_mean %0d m_var %0d", $time,
                     results_if.class_code, results_if.entropy_mean,
                     results_if.miss_mean, results_if.miss_variance);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (samples_if.valid && samples_if.ready) begin
        update_window(samples_if.entropy_q8, samples_if.miss_sample);
        acc_cnt <= acc_cnt + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin : stim
    int tx_pct [4];
    int rx_pct [4];
    int total;
    int phase;
    int burst;
    int e_base;
    int e_jit;
    logic [MISS_W-1:0] m_base;
    int m_jit;
    int e_edges [12];
    tx_pct  = '{0, 82, 0, 28};
    rx_pct  = '{0, 0, 82, 28};
    e_edges = '{0, 26, 27, 77, 78, 128, 129, 179, 180, 230, 231, 256};

    // directed: empty window, saturation, wrap, then steady windows
    push_sample(9'd0, 32'd0, 0, 0, 1'b0);
    push_sample(9'd511, 32'hFFFF_FFFF, 0, 0, 1'b0);
    push_sample(9'd257, 32'hFFFF_FFFF, 0, 0, 1'b0);
    push_sample(9'd256, 32'h8000_0000, 0, 0, 1'b0);
    for (int i = 0; i < 8; i++) push_sample(9'd256, 32'd1000, 0, 0, 1'b0);
    for (int i = 0; i < 4; i++) push_sample(9'd200, 32'd600, 0, 0, 1'b0);
    for (int i = 0; i < 4; i++) push_sample(9'd140, 32'd7, 0, 0, 1'b0);
    for (int i = 0; i < 3; i++) push_sample(9'd20, 32'd3, 0, 0, 1'b0);
    total = pending.size();

    // random: bursts of steady windows near the thresholds, and noise
    while (total < NUM_SAMPLES) begin
      phase = ((total - 23) * 4) / (NUM_SAMPLES - 23);
      if (phase > 3) phase = 3;
      if ($urandom_range(0, 99) < 75) begin
        burst = $urandom_range(8, 24);
        e_base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 256)
                                             : e_edges[$urandom_range(0, 11)];
        e_jit = $urandom_range(0, 3);
        case ($urandom_range(0, 6))
          0: m_base = 32'd0;
          1: m_base = 32'd500;
          2: m_base = 32'd800;
          3: m_base = $urandom_range(0, 2000);
          4: m_base = $urandom;
          5: m_base = 32'hFFFF_FFFF - $urandom_range(0, 300);
          default: m_base = $urandom_range(400, 900);
        endcase
        case ($urandom_range(0, 4))
          0: m_jit = 0;
          1: m_jit = 1;
          2: m_jit = 30;
          3: m_jit = 100;
          default: m_jit = 300;
        endcase
        for (int i = 0; i < burst; i++) begin
          push_sample(9'(e_base + $urandom_range(0, e_jit)),
                      m_base + $urandom_range(0, m_jit),
                      tx_pct[phase], rx_pct[phase], 1'b0);
        end
        total += burst;
      end else begin
        burst = $urandom_range(1, 6);
        for (int i = 0; i < burst; i++) begin
          push_sample(9'($urandom_range(0, 511)), $urandom,
                      tx_pct[phase], rx_pct[phase], 1'b0);
        end
        total += burst;
      end
    end

    // sender holds off at the start of each random phase until all results are in
    for (int i = 23; i < pending.size(); i++) begin
      if (i == 23 || pending[i].tx_idle != pending[i-1].tx_idle ||
          pending[i].rx_stall != pending[i-1].rx_stall) begin
        pending[i].drain = 1'b1;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || sent_cnt != acc_cnt || window_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && window_results.size() == 0) begin
      $display("windowed_stats_classifier_core: match");
    end else begin
      $display("windowed_stats_classifier_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/wsc_pkg.sv
design/wsc_in_if.sv
design/wsc_out_if.sv
design/wsc_front.sv
design/wsc_queue.sv
design/wsc_back.sv
design/windowed_stats_classifier_core.sv
design/wsc_checker.sv
bench/tb_windowed_stats_classifier_core.sv
